### rtl/lmhf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmhf_pkg
// Shared widths, word layouts, defaults and command codes of the line-mark
// hole finder.
// ----------------------------------------------------------------------------
package lmhf_pkg;

    // field widths
    localparam int CMD_W  = 3;
    localparam int BLK_W  = 4;
    localparam int OFS_W  = 14;
    localparam int SIZE_W = 15;
    localparam int LINE_W = 8;
    localparam int LIVE_W = 7;

    // input word: s_tdata = {pad, size_bytes, byte_offset, block_index}
    localparam int S_TDATA_W  = 40;
    localparam int S_BLK_LSB  = 0;
    localparam int S_OFS_LSB  = S_BLK_LSB + BLK_W;
    localparam int S_SIZE_LSB = S_OFS_LSB + OFS_W;

    // result word: m_tdata = {pad, range_error, live_count, end, start, found}
    localparam int M_TDATA_W   = 32;
    localparam int M_FOUND_BIT = 0;
    localparam int M_START_LSB = 1;
    localparam int M_END_LSB   = M_START_LSB + LINE_W;
    localparam int M_LIVE_LSB  = M_END_LSB + LINE_W;
    localparam int M_RERR_BIT  = M_LIVE_LSB + LIVE_W;

    // lines examined per walk step
    localparam int LANES = 8;

    // parameter defaults
    localparam int DEF_LINES_PER_BLOCK   = 128;
    localparam int DEF_LINE_BYTES        = 128;
    localparam int DEF_NUM_BLOCKS        = 16;
    localparam int DEF_FIRST_USABLE_LINE = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACTIVATE = 3'd0,
        CMD_MARK     = 3'd1,
        CMD_FIND     = 3'd2,
        CMD_COUNT    = 3'd3,
        CMD_RESTART  = 3'd4
    } cmd_t;

endpackage

### rtl/line_mark_hole_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_mark_hole_finder
// Per-block line mark bitmaps and scan positions with activate, mark, hole
// search, live count and scan restart commands.
// ----------------------------------------------------------------------------
// Sequence: the input word is taken in idle and the block's row is loaded;
//   activate, mark, restart and unknown commands then finish, find walks
//   8-line groups from the scan position's group, count walks every group;
//   the result word is loaded once the output register is free.
// One command in flight: the next word is taken only after the result is
//   loaded and the block is idle again. Reset clears the per-block valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module line_mark_hole_finder #(
    parameter int LINES_PER_BLOCK   = lmhf_pkg::DEF_LINES_PER_BLOCK,
    parameter int LINE_BYTES        = lmhf_pkg::DEF_LINE_BYTES,
    parameter int NUM_BLOCKS        = lmhf_pkg::DEF_NUM_BLOCKS,
    parameter int FIRST_USABLE_LINE = lmhf_pkg::DEF_FIRST_USABLE_LINE
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, low bit up: block_index[3:0], byte_offset[13:0], size_bytes[14:0]
    input  logic [lmhf_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: command[2:0]
    input  logic [lmhf_pkg::CMD_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, low bit up: found, hole_begin[7:0], hole_end[7:0],
    // live_count[6:0], range_error
    output logic [lmhf_pkg::M_TDATA_W-1:0] m_tdata
);
    import lmhf_pkg::*;

    // One walk step covers LANES lines; the extended row carries marked
    // sentinel lines past the block end so every hole has a closing mark.
    localparam int STEPS   = LINES_PER_BLOCK / LANES + 1;
    localparam int EXT_W   = STEPS * LANES;
    localparam int LW      = $clog2(EXT_W);
    localparam int CW      = $clog2(STEPS);
    localparam int LANE_SH = $clog2(LANES);
    localparam int AW      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BIW     = (AW > BLK_W) ? AW : BLK_W;
    localparam int PW      = LW + $clog2(LINE_BYTES + 1);
    localparam int CMPW    = (PW > SIZE_W) ? PW : SIZE_W;
    localparam int BSPAN_W = $clog2(LINES_PER_BLOCK * LINE_BYTES + 1);
    localparam int BW      = ((BSPAN_W > SIZE_W) ? BSPAN_W : SIZE_W) + 1;
    localparam logic [LINES_PER_BLOCK-1:0] RESET_ROW = LINES_PER_BLOCK'(1);
    localparam logic [LW-1:0]              FIRST_POS = LW'(FIRST_USABLE_LINE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_FINISH
    } state_t;

    // input word fields
    logic [BLK_W-1:0]  s_blk;
    logic [OFS_W-1:0]  s_ofs;
    logic [SIZE_W-1:0] s_size;
    logic [BIW-1:0]    s_blk_ext;
    logic              s_acc;

    assign s_blk     = s_tdata[S_BLK_LSB +: BLK_W];
    assign s_ofs     = s_tdata[S_OFS_LSB +: OFS_W];
    assign s_size    = s_tdata[S_SIZE_LSB +: SIZE_W];
    assign s_blk_ext = BIW'(s_blk);

    // control registers
    state_t                state_reg,     state_next;
    logic [NUM_BLOCKS-1:0] valid_reg,     valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg,  out_data_next;

    // payload and working registers
    cmd_t                  cmd_reg,     cmd_next;
    logic [AW-1:0]         addr_reg,    addr_next;
    logic                  blk_ok_reg,  blk_ok_next;
    logic [OFS_W-1:0]      ofs_reg,     ofs_next;
    logic [SIZE_W-1:0]     size_reg,    size_next;
    logic [LINES_PER_BLOCK-1:0] row_reg, row_next;
    logic [LW-1:0]         pos_reg,     pos_next;
    logic [CW-1:0]         chunk_reg,   chunk_next;
    logic                  in_hole_reg, in_hole_next;
    logic                  done_reg,    done_next;
    logic                  found_reg,   found_next;
    logic [LW-1:0]         hs_reg,      hs_next;
    logic [LW-1:0]         he_reg,      he_next;
    logic [LW-1:0]         cnt_reg,     cnt_next;
    logic                  rerr_reg,    rerr_next;

    // state memories, one row per block
    logic [LINES_PER_BLOCK-1:0] mark_mem [NUM_BLOCKS];
    logic [LW-1:0]              scan_mem [NUM_BLOCKS];
    logic [LINES_PER_BLOCK-1:0] mark_rd_reg;
    logic [LW-1:0]              scan_rd_reg;
    logic                       mem_we;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Read the addressed block's row on accept; write back the working row
    // and scan position when the command retires.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[addr_reg] <= row_reg;
            scan_mem[addr_reg] <= pos_reg;
        end
        if (s_acc) begin
            mark_rd_reg <= mark_mem[s_blk_ext[AW-1:0]];
            scan_rd_reg <= scan_mem[s_blk_ext[AW-1:0]];
        end
    end

    // Rows never written since reset read as the reset row.
    logic [LINES_PER_BLOCK-1:0] row_eff;
    logic [LW-1:0]              pos_eff;

    assign row_eff = valid_reg[addr_reg] ? mark_rd_reg : RESET_ROW;
    assign pos_eff = valid_reg[addr_reg] ? scan_rd_reg : FIRST_POS;

    // Mark mask: line l is covered when its byte span overlaps
    // [offset, offset + size). Range error when the end passes the block.
    logic [BW-1:0]              ofs_ext;
    logic [BW-1:0]              obj_end;
    logic [LINES_PER_BLOCK-1:0] mark_mask;
    logic                       mark_rerr;
    logic                       mark_do;

    assign ofs_ext   = BW'(ofs_reg);
    assign obj_end   = BW'(ofs_reg) + BW'(size_reg);
    assign mark_rerr = (size_reg != '0) &&
                       (obj_end > BW'(LINES_PER_BLOCK * LINE_BYTES));
    assign mark_do   = (size_reg != '0) && !mark_rerr;

    always_comb begin
        for (int l = 0; l < LINES_PER_BLOCK; l++) begin
            mark_mask[l] = (BW'((l + 1) * LINE_BYTES) > ofs_ext) &&
                           (BW'(l * LINE_BYTES) < obj_end);
        end
    end

    // Walk step: examine LANES lines of the current group.
    logic [EXT_W-1:0] ext_row;
    logic [LANES-1:0] grp_bits;
    logic             walk_ih;
    logic             walk_done;
    logic             walk_found;
    logic [LW-1:0]    walk_hs;
    logic [LW-1:0]    walk_he;
    logic [LW-1:0]    walk_sp;
    logic [LW-1:0]    walk_cnt;

    assign ext_row  = {{(EXT_W - LINES_PER_BLOCK){1'b1}}, row_reg};
    assign grp_bits = ext_row[32'(chunk_reg) * LANES +: LANES];

    always_comb begin
        logic [LW-1:0] ln;
        walk_ih    = in_hole_reg;
        walk_done  = done_reg;
        walk_found = found_reg;
        walk_hs    = hs_reg;
        walk_he    = he_reg;
        walk_sp    = pos_reg;
        walk_cnt   = cnt_reg;
        for (int i = 0; i < LANES; i++) begin
            ln = LW'(32'(chunk_reg) * LANES + i);
            if (cmd_reg == CMD_COUNT) begin
                if (ln != '0 && ln < LW'(LINES_PER_BLOCK) && grp_bits[i]) begin
                    walk_cnt = walk_cnt + LW'(1);
                end
            end else if (!walk_done && ln >= pos_reg) begin
                if (!walk_ih) begin
                    // open a hole at the first free line
                    if (!grp_bits[i]) begin
                        walk_ih = 1'b1;
                        walk_hs = ln;
                    end
                end else if (grp_bits[i]) begin
                    // hole closes here; advance the scan past it
                    walk_sp = ln;
                    if (CMPW'(ln - walk_hs) * CMPW'(LINE_BYTES) >= CMPW'(size_reg)) begin
                        walk_found = 1'b1;
                        walk_done  = 1'b1;
                        walk_he    = ln;
                    end else begin
                        walk_ih = 1'b0;
                    end
                end
                // no hole can start at or past the block end
                if (ln >= LW'(LINES_PER_BLOCK)) begin
                    walk_done = 1'b1;
                end
            end
        end
    end

    // Next-state logic
    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        blk_ok_next    = blk_ok_reg;
        ofs_next       = ofs_reg;
        size_next      = size_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        chunk_next     = chunk_reg;
        in_hole_next   = in_hole_reg;
        done_next      = done_reg;
        found_next     = found_reg;
        hs_next        = hs_reg;
        he_next        = he_reg;
        cnt_next       = cnt_reg;
        rerr_next      = rerr_reg;
        mem_we         = 1'b0;

        // drop the result word once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = cmd_t'(s_tuser);
                    addr_next   = s_blk_ext[AW-1:0];
                    blk_ok_next = (32'(s_blk) < 32'(NUM_BLOCKS));
                    ofs_next    = s_ofs;
                    size_next   = s_size;
                    state_next  = ST_LOAD;
                end
            end

            ST_LOAD: begin
                found_next   = 1'b0;
                rerr_next    = 1'b0;
                cnt_next     = '0;
                in_hole_next = 1'b0;
                done_next    = 1'b0;
                hs_next      = '0;
                he_next      = '0;
                chunk_next   = '0;
                row_next     = row_eff;
                pos_next     = pos_eff;
                state_next   = ST_FINISH;
                if (blk_ok_reg) begin
                    case (cmd_reg)
                        CMD_ACTIVATE: begin
                            row_next = RESET_ROW;
                            pos_next = FIRST_POS;
                        end
                        CMD_MARK: begin
                            rerr_next = mark_rerr;
                            if (mark_do) begin
                                row_next = row_eff | mark_mask;
                            end
                        end
                        CMD_FIND: begin
                            chunk_next = CW'(pos_eff >> LANE_SH);
                            done_next  = (pos_eff >= LW'(LINES_PER_BLOCK));
                            state_next = ST_WALK;
                        end
                        CMD_COUNT: begin
                            state_next = ST_WALK;
                        end
                        CMD_RESTART: begin
                            pos_next = FIRST_POS;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                in_hole_next = walk_ih;
                done_next    = walk_done;
                found_next   = walk_found;
                hs_next      = walk_hs;
                he_next      = walk_he;
                pos_next     = walk_sp;
                cnt_next     = walk_cnt;
                if (walk_done || chunk_reg == CW'(STEPS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    chunk_next = chunk_reg + CW'(1);
                end
            end

            ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    mem_we = blk_ok_reg;
                    if (blk_ok_reg) begin
                        valid_next[addr_reg] = 1'b1;
                    end
                    out_data_next              = '0;
                    out_data_next[M_FOUND_BIT] = found_reg;
                    if (found_reg) begin
                        out_data_next[M_START_LSB +: LINE_W] = LINE_W'(hs_reg);
                        out_data_next[M_END_LSB +: LINE_W]   = LINE_W'(he_reg);
                    end
                    out_data_next[M_LIVE_LSB +: LIVE_W] = LIVE_W'(cnt_reg);
                    out_data_next[M_RERR_BIT]           = rerr_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Command payload and walk registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        addr_reg    <= addr_next;
        blk_ok_reg  <= blk_ok_next;
        ofs_reg     <= ofs_next;
        size_reg    <= size_next;
        row_reg     <= row_next;
        pos_reg     <= pos_next;
        chunk_reg   <= chunk_next;
        in_hole_reg <= in_hole_next;
        done_reg    <= done_next;
        found_reg   <= found_next;
        hs_reg      <= hs_next;
        he_reg      <= he_next;
        cnt_reg     <= cnt_next;
        rerr_reg    <= rerr_next;
    end

endmodule

### rtl/lmhf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmhf_checker
// Port-level checks of the line-mark hole finder, bound to the top level.
// ----------------------------------------------------------------------------
module lmhf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lmhf_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [lmhf_pkg::CMD_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lmhf_pkg::M_TDATA_W-1:0] m_tdata
);
    import lmhf_pkg::*;

    logic s_acc;
    logic quiet_cmd;

    assign s_acc     = s_tvalid && s_tready;
    // commands that must give an all-zero result word
    assign quiet_cmd = (s_tuser > CMD_W'(CMD_RESTART)) ||
                       (s_tuser == CMD_W'(CMD_MARK) &&
                        s_tdata[S_SIZE_LSB +: SIZE_W] == '0);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("second word taken while a command is in flight");

    a_quiet_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !m_tvalid && quiet_cmd |-> ##3 (m_tvalid && m_tdata == '0))
        else $error("unknown command or empty mark gave a nonzero result");

    a_found_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_FOUND_BIT] |->
            (m_tdata[M_START_LSB +: LINE_W] < m_tdata[M_END_LSB +: LINE_W]) &&
            !m_tdata[M_RERR_BIT] && (m_tdata[M_LIVE_LSB +: LIVE_W] == '0))
        else $error("found hole with bad bounds or mixed fields");

endmodule

bind line_mark_hole_finder lmhf_checker u_lmhf_checker (.*);

### tb/line_mark_hole_finder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_mark_hole_finder_checker
// Watches both stream channels of the hole finder, keeps its own copy of the
// line bitmaps and scan positions, and checks every result word in order.
// ----------------------------------------------------------------------------
module line_mark_hole_finder_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lmhf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [lmhf_pkg::CMD_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lmhf_pkg::M_TDATA_W-1:0] m_tdata,
    output int unsigned                    mismatch_count,
    output int unsigned                    pending_words
);
    import lmhf_pkg::*;

    localparam int LINES      = DEF_LINES_PER_BLOCK;
    localparam int LINE_BYTES = DEF_LINE_BYTES;
    localparam int BLOCKS     = DEF_NUM_BLOCKS;
    localparam int FIRST_LINE = DEF_FIRST_USABLE_LINE;
    localparam int PAD_LSB    = M_RERR_BIT + 1;

    typedef struct packed {
        logic              found;
        logic [LINE_W-1:0] hole_begin;
        logic [LINE_W-1:0] hole_stop;
        logic [LIVE_W-1:0] live;
        logic              range_err;
    } hole_result_t;

    logic [LINES-1:0] line_map [BLOCKS];
    logic [LINE_W-1:0] scan_pos [BLOCKS];
    hole_result_t expected_q [$];
    int unsigned word_count;

    // Apply one command to the shadow state and return the result it gives.
    function automatic hole_result_t apply_command(logic [CMD_W-1:0] cmd, int blk,
                                                   int ofs, int size);
        hole_result_t r;
        int lo_line;
        int hi_line;
        int pos;
        int start;
        int stop;
        r = '0;
        if (blk >= BLOCKS) return r;
        case (cmd)
            CMD_ACTIVATE: begin
                line_map[blk] = '0;
                line_map[blk][0] = 1'b1;
                scan_pos[blk] = LINE_W'(FIRST_LINE);
            end
            CMD_MARK: begin
                if (size != 0) begin
                    lo_line = ofs / LINE_BYTES;
                    hi_line = (ofs + size - 1) / LINE_BYTES;
                    if (hi_line >= LINES) begin
                        r.range_err = 1'b1;
                    end else begin
                        for (int l = lo_line; l <= hi_line; l++)
                            line_map[blk][l] = 1'b1;
                    end
                end
            end
            CMD_FIND: begin
                pos = int'(scan_pos[blk]);
                while (1) begin
                    start = pos;
                    while (start < LINES && line_map[blk][start]) start++;
                    if (start >= LINES) break;
                    stop = start;
                    while (stop < LINES && !line_map[blk][stop]) stop++;
                    pos = stop;
                    scan_pos[blk] = LINE_W'(stop);
                    if ((stop - start) * LINE_BYTES >= size) begin
                        r.found      = 1'b1;
                        r.hole_begin = LINE_W'(start);
                        r.hole_stop  = LINE_W'(stop);
                        break;
                    end
                end
            end
            CMD_COUNT: begin
                r.live = LIVE_W'($countones(line_map[blk] &
                                            ~{{(LINES-1){1'b0}}, 1'b1}));
            end
            CMD_RESTART: begin
                scan_pos[blk] = LINE_W'(FIRST_LINE);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] result word %0d: %s got %0d, expected %0d",
                 $realtime, word_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        hole_result_t want;
        if (!aresetn) begin
            for (int b = 0; b < BLOCKS; b++) begin
                line_map[b] = '0;
                line_map[b][0] = 1'b1;
                scan_pos[b] = LINE_W'(FIRST_LINE);
            end
            expected_q.delete();
            mismatch_count = 0;
            word_count     = 0;
        end else begin
            // Pop before push: a word taken at this edge belongs to an older command.
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", int'(m_tdata), 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[M_FOUND_BIT] !== want.found)
                        report_mismatch("found", int'(m_tdata[M_FOUND_BIT]),
                                        int'(want.found));
                    if (m_tdata[M_START_LSB +: LINE_W] !== want.hole_begin)
                        report_mismatch("hole begin line",
                                        int'(m_tdata[M_START_LSB +: LINE_W]),
                                        int'(want.hole_begin));
                    if (m_tdata[M_END_LSB +: LINE_W] !== want.hole_stop)
                        report_mismatch("hole end line",
                                        int'(m_tdata[M_END_LSB +: LINE_W]),
                                        int'(want.hole_stop));
                    if (m_tdata[M_LIVE_LSB +: LIVE_W] !== want.live)
                        report_mismatch("live count",
                                        int'(m_tdata[M_LIVE_LSB +: LIVE_W]),
                                        int'(want.live));
                    if (m_tdata[M_RERR_BIT] !== want.range_err)
                        report_mismatch("range_error", int'(m_tdata[M_RERR_BIT]),
                                        int'(want.range_err));
                    if (m_tdata[M_TDATA_W-1:PAD_LSB] !== '0)
                        report_mismatch("pad bits",
                                        int'(m_tdata[M_TDATA_W-1:PAD_LSB]), 0);
                end
                word_count++;
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_command(s_tuser,
                                                   int'(s_tdata[S_BLK_LSB +: BLK_W]),
                                                   int'(s_tdata[S_OFS_LSB +: OFS_W]),
                                                   int'(s_tdata[S_SIZE_LSB +: SIZE_W])));
        end
        pending_words = expected_q.size();
    end

endmodule

### tb/line_mark_hole_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_mark_hole_finder_tb
// Drives command words into the hole finder: a directed pass over the field
// extremes and corner cases, then three random phases with different idle
// patterns on each side. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module line_mark_hole_finder_tb;
    import lmhf_pkg::*;

    localparam int PHASE_WORDS = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int UNKNOWN_LO = int'(CMD_RESTART) + 1;
    localparam int UNKNOWN_HI = (1 << CMD_W) - 1;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int unsigned          mismatch_count;
    int unsigned          pending_words;

    // Idle percentages of the sender and the receiver, changed per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    line_mark_hole_finder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    line_mark_hole_finder_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    // Stall the result channel at random; one decision per cycle.
    always @(negedge aclk) begin
        m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one command word. Call at a falling edge; returns at a falling edge.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input int blk,
                             input int ofs, input int size);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_BLK_LSB +: BLK_W]   = BLK_W'(blk);
        word[S_OFS_LSB +: OFS_W]   = OFS_W'(ofs);
        word[S_SIZE_LSB +: SIZE_W] = SIZE_W'(size);
        // Hold valid low for a random gap first.
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Hold the sender until every expected word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
    endtask

    // Pick one random command. Most traffic is small marks and finds on a few
    // blocks so that bitmaps fill up and hole walks go deep; the rest is counts,
    // restarts, activates, oversized objects, unknown codes and fully random words.
    task automatic send_random_word();
        int pick;
        int blk;
        int ofs;
        int size;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(99);
        blk  = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(15);
        ofs  = $urandom_range(16383);
        size = 0;
        if (pick < 40) begin
            cmd  = CMD_MARK;
            pick = $urandom_range(99);
            if (pick < 80)      size = $urandom_range(1, 400);
            else if (pick < 92) size = $urandom_range(32767);
            else if (pick < 96) size = 0;
            else                size = 16384 - ofs + $urandom_range(1);
        end else if (pick < 70) begin
            cmd  = CMD_FIND;
            ofs  = $urandom_range(16383);
            pick = $urandom_range(99);
            if (pick < 75)      size = $urandom_range(1024);
            else if (pick < 85) size = 0;
            else                size = $urandom_range(32767);
        end else if (pick < 80) begin
            cmd = CMD_COUNT;
        end else if (pick < 88) begin
            cmd = CMD_RESTART;
        end else if (pick < 92) begin
            cmd = CMD_ACTIVATE;
        end else if (pick < 96) begin
            cmd  = CMD_W'($urandom_range(UNKNOWN_LO, UNKNOWN_HI));
            size = $urandom_range(32767);
        end else begin
            cmd  = CMD_W'($urandom_range(UNKNOWN_HI));
            size = $urandom_range(32767);
        end
        send_word(cmd, blk, ofs, size);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (PHASE_WORDS) send_random_word();
        drain_results();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pass: fresh blocks, field extremes, every command.
        send_word(CMD_COUNT,    0, 0, 0);
        send_word(CMD_FIND,     0, 0, 0);        // zero-size request takes the whole block
        send_word(CMD_FIND,     0, 0, 0);        // scan at the end: no hole left
        send_word(CMD_RESTART,  0, 0, 0);
        send_word(CMD_MARK,     0, 0, 1);        // reserved line again
        send_word(CMD_MARK,     0, 16383, 1);    // last line of the block
        send_word(CMD_MARK,     0, 16383, 2);    // one byte past the block
        send_word(CMD_MARK,     0, 200, 0);      // zero-size object
        send_word(CMD_MARK,     0, 0, 32767);    // largest size
        send_word(CMD_MARK,     1, 256, 384);
        send_word(CMD_MARK,     15, 1000, 128);
        send_word(CMD_FIND,     0, 0, 16384);    // larger than any hole
        send_word(CMD_FIND,     1, 0, 128);
        send_word(CMD_FIND,     1, 0, 32767);
        send_word(CMD_COUNT,    0, 0, 0);
        send_word(CMD_COUNT,    1, 0, 0);
        send_word(CMD_ACTIVATE, 1, 0, 0);
        send_word(CMD_COUNT,    1, 0, 0);
        for (int c = UNKNOWN_LO; c <= UNKNOWN_HI; c++)
            send_word(CMD_W'(c), 2, 16383, 32767);
        send_word(CMD_RESTART,  15, 0, 0);
        send_word(CMD_FIND,     15, 0, 0);
        send_word(CMD_FIND,     15, 16383, 1);
        drain_results();

        run_phase(34, 70);
        run_phase(70, 34);
        run_phase(0, 0);

        s_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("line_mark_hole_finder test passed");
        end else begin
            $display("line_mark_hole_finder test failed");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(2_000_000);
        $display("line_mark_hole_finder test failed");
        $finish;
    end

endmodule
